@@ design/cbag_pkg.sv @@
// Shared types, constants and helpers for the clipped rectangle blit address generator.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package cbag_pkg;

    localparam int MAX_DIM     = 2048;
    localparam int DIM_W       = 12;
    localparam int COORD_W     = 13;
    localparam int IDX_W       = 22;
    localparam int CLIP_W      = 16;
    localparam int CFG_IDX_W   = 2;
    // must be a power of two, pointers wrap naturally
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_W = 2'd0,
        REG_SRC_H = 2'd1,
        REG_DST_W = 2'd2,
        REG_DST_H = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] src_w;
        logic [DIM_W-1:0] src_h;
        logic [DIM_W-1:0] dst_w;
        logic [DIM_W-1:0] dst_h;
    } t_dims;

    typedef struct packed {
        t_op              op;
        logic             empty;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] sx;
        logic [DIM_W-1:0] sy;
        logic [DIM_W-1:0] dx;
        logic [DIM_W-1:0] dy;
    } t_clip;

    typedef struct packed {
        t_op              op;
        logic             empty;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [IDX_W-1:0] src_base;
        logic [IDX_W-1:0] dst_base;
    } t_cmd;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] res;
        res = r;
        if ({1'b0, r} > (DIM_W+1)'(MAX_DIM))
            res = DIM_W'(MAX_DIM);
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/cbag_if.sv @@
// Channel interfaces: blit request, result and configuration write.
// Depends on cbag_pkg.
`default_nettype none

interface cbag_req_if;
    logic                                 valid;
    logic                                 ready;
    cbag_pkg::t_op                        op;
    logic                                 whole_source;
    logic signed [cbag_pkg::COORD_W-1:0]  src_x;
    logic signed [cbag_pkg::COORD_W-1:0]  src_y;
    logic [cbag_pkg::DIM_W-1:0]           rect_width;
    logic [cbag_pkg::DIM_W-1:0]           rect_height;
    logic signed [cbag_pkg::COORD_W-1:0]  dst_x;
    logic signed [cbag_pkg::COORD_W-1:0]  dst_y;

    modport source (output valid, op, whole_source, src_x, src_y, rect_width, rect_height,
                    dst_x, dst_y, input ready);
    modport sink   (input valid, op, whole_source, src_x, src_y, rect_width, rect_height,
                    dst_x, dst_y, output ready);
endinterface

interface cbag_res_if;
    logic                         valid;
    logic                         ready;
    logic                         empty_res;
    logic                         size_valid;
    logic [cbag_pkg::DIM_W-1:0]   clipped_width;
    logic [cbag_pkg::DIM_W-1:0]   clipped_height;
    logic                         pair_valid;
    logic [cbag_pkg::IDX_W-1:0]   source_index;
    logic [cbag_pkg::IDX_W-1:0]   dest_index;
    logic                         last;

    modport source (output valid, empty_res, size_valid, clipped_width, clipped_height,
                    pair_valid, source_index, dest_index, last, input ready);
    modport sink   (input valid, empty_res, size_valid, clipped_width, clipped_height,
                    pair_valid, source_index, dest_index, last, output ready);
endinterface

interface cbag_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cbag_pkg::CFG_IDX_W-1:0]   index;
    logic [cbag_pkg::DIM_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/cbag_regs.sv @@
// Surface size registers and their effective (MAX_DIM limited) values.
// Depends on cbag_pkg and cbag_cfg_if.
`default_nettype none

module cbag_regs (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    cbag_cfg_if.sink            i_cfg,
    output cbag_pkg::t_dims     o_dims
);

    logic [cbag_pkg::DIM_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= cbag_pkg::DIM_W'(400);
            r_src_h <= cbag_pkg::DIM_W'(300);
            r_dst_w <= cbag_pkg::DIM_W'(400);
            r_dst_h <= cbag_pkg::DIM_W'(300);
        end else if (i_cfg.valid) begin
            case (cbag_pkg::t_reg_idx'(i_cfg.index))
                cbag_pkg::REG_SRC_W: r_src_w <= i_cfg.data;
                cbag_pkg::REG_SRC_H: r_src_h <= i_cfg.data;
                cbag_pkg::REG_DST_W: r_dst_w <= i_cfg.data;
                cbag_pkg::REG_DST_H: r_dst_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_dims.src_w = cbag_pkg::eff_dim(r_src_w);
    assign o_dims.src_h = cbag_pkg::eff_dim(r_src_h);
    assign o_dims.dst_w = cbag_pkg::eff_dim(r_dst_w);
    assign o_dims.dst_h = cbag_pkg::eff_dim(r_dst_h);

endmodule

`default_nettype wire

@@ design/cbag_front.sv @@
// Front end: accepts requests, clips each one, then forms the row base indices.
// Depends on cbag_pkg and cbag_req_if.
`default_nettype none

module cbag_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    cbag_req_if.sink            i_req,
    input  cbag_pkg::t_dims     i_dims,
    output logic                o_cmd_valid,
    output cbag_pkg::t_cmd      o_cmd,
    input  wire                 i_cmd_ready
);

    localparam int CW = cbag_pkg::CLIP_W;
    localparam int DW = cbag_pkg::DIM_W;
    localparam int XW = cbag_pkg::COORD_W;
    localparam int IW = cbag_pkg::IDX_W;

    logic             r_a_valid, r_b_valid;
    cbag_pkg::t_clip  r_a, n_a;
    cbag_pkg::t_cmd   r_b, n_b;
    logic             a_ready, b_ready;
    logic [2*DW-1:0]  src_prod, dst_prod;

    assign b_ready     = !r_b_valid || i_cmd_ready;
    assign a_ready     = !r_a_valid || b_ready;
    assign i_req.ready = a_ready;

    // stage A: clipping
    always_comb begin
        logic signed [CW-1:0] sx, sy, w, h, dx, dy, sw, sh, dw, dh;
        sw = $signed({{(CW-DW){1'b0}}, i_dims.src_w});
        sh = $signed({{(CW-DW){1'b0}}, i_dims.src_h});
        dw = $signed({{(CW-DW){1'b0}}, i_dims.dst_w});
        dh = $signed({{(CW-DW){1'b0}}, i_dims.dst_h});
        if (i_req.whole_source) begin
            sx = '0;
            sy = '0;
            w  = sw;
            h  = sh;
        end else begin
            sx = $signed({{(CW-XW){i_req.src_x[XW-1]}}, i_req.src_x});
            sy = $signed({{(CW-XW){i_req.src_y[XW-1]}}, i_req.src_y});
            w  = $signed({{(CW-DW){1'b0}}, i_req.rect_width});
            h  = $signed({{(CW-DW){1'b0}}, i_req.rect_height});
        end
        dx = $signed({{(CW-XW){i_req.dst_x[XW-1]}}, i_req.dst_x});
        dy = $signed({{(CW-XW){i_req.dst_y[XW-1]}}, i_req.dst_y});

        if (sx < 0) begin
            w  = w + sx;
            dx = dx - sx;
            sx = '0;
        end
        if (sy < 0) begin
            h  = h + sy;
            dy = dy - sy;
            sy = '0;
        end
        if (dx < 0) begin
            w  = w + dx;
            sx = sx - dx;
            dx = '0;
        end
        if (dy < 0) begin
            h  = h + dy;
            sy = sy - dy;
            dy = '0;
        end

        n_a.op    = i_req.op;
        n_a.empty = (sx >= sw) || (sy >= sh) || (dx >= dw) || (dy >= dh);

        if (sw - sx < w) w = sw - sx;
        if (sh - sy < h) h = sh - sy;
        if (dw - dx < w) w = dw - dx;
        if (dh - dy < h) h = dh - dy;
        if (w < 0 || n_a.empty) w = '0;
        if (h < 0 || n_a.empty) h = '0;

        n_a.w  = w[DW-1:0];
        n_a.h  = h[DW-1:0];
        n_a.sx = sx[DW-1:0];
        n_a.sy = sy[DW-1:0];
        n_a.dx = dx[DW-1:0];
        n_a.dy = dy[DW-1:0];
    end

    // stage B: row base = row * stride + column
    assign src_prod = r_a.sy * i_dims.src_w;
    assign dst_prod = r_a.dy * i_dims.dst_w;

    always_comb begin
        n_b.op       = r_a.op;
        n_b.empty    = r_a.empty;
        n_b.w        = r_a.w;
        n_b.h        = r_a.h;
        n_b.src_base = src_prod[IW-1:0] + IW'(r_a.sx);
        n_b.dst_base = dst_prod[IW-1:0] + IW'(r_a.dx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready)
                r_a_valid <= i_req.valid;
            if (b_ready)
                r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && a_ready)
            r_a <= n_a;
        if (r_a_valid && b_ready)
            r_b <= n_b;
    end

    assign o_cmd_valid = r_b_valid;
    assign o_cmd       = r_b;

endmodule

`default_nettype wire

@@ design/cbag_queue.sv @@
// Short command queue between the front end and the index sequencer.
// Depends on cbag_pkg.
`default_nettype none

module cbag_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  cbag_pkg::t_cmd      i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output cbag_pkg::t_cmd      o_data
);

    localparam int PW = cbag_pkg::QPTR_W;

    cbag_pkg::t_cmd     r_mem [cbag_pkg::QUEUE_DEPTH];
    logic [PW-1:0]      r_wr, r_rd;
    logic [PW:0]        r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == (PW+1)'(cbag_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push)
                r_wr <= r_wr + 1'b1;
            if (do_pop)
                r_rd <= r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr] <= i_data;
    end

endmodule

`default_nettype wire

@@ design/cbag_back.sv @@
// Back end: holds the blit state, walks the rectangle and registers each result.
// Depends on cbag_pkg and cbag_res_if.
`default_nettype none

module cbag_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  cbag_pkg::t_dims     i_dims,
    input  wire                 i_cmd_valid,
    input  cbag_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    cbag_res_if.source          o_res
);

    localparam int DW = cbag_pkg::DIM_W;
    localparam int IW = cbag_pkg::IDX_W;

    logic             r_out_valid;
    logic             r_active;
    logic [DW-1:0]    r_copy_w, r_copy_h, r_col, r_row;
    logic [IW-1:0]    r_src_base, r_dst_base;

    logic             r_empty_res, r_size_valid, r_pair_valid, r_last;
    logic [DW-1:0]    r_clip_w, r_clip_h;
    logic [IW-1:0]    r_src_idx, r_dst_idx;

    logic             n_empty_res, n_size_valid, n_pair_valid, n_last;
    logic [DW-1:0]    n_clip_w, n_clip_h;
    logic [IW-1:0]    n_src_idx, n_dst_idx;

    logic             take, row_end, blit_end;
    logic [DW:0]      col_inc, row_inc;

    assign take      = i_cmd_valid && (!r_out_valid || o_res.ready);
    assign o_cmd_pop = take;
    assign col_inc   = {1'b0, r_col} + 1'b1;
    assign row_inc   = {1'b0, r_row} + 1'b1;
    assign row_end   = (col_inc == {1'b0, r_copy_w});
    assign blit_end  = row_end && (row_inc == {1'b0, r_copy_h});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_copy_w    <= '0;
            r_copy_h    <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_src_base  <= '0;
            r_dst_base  <= '0;
        end else begin
            r_out_valid <= take || (r_out_valid && !o_res.ready);
            if (take) begin
                case (i_cmd.op)
                    cbag_pkg::OP_START: begin
                        r_col    <= '0;
                        r_row    <= '0;
                        r_copy_w <= i_cmd.w;
                        r_copy_h <= i_cmd.h;
                        r_active <= !i_cmd.empty && (i_cmd.w != '0) && (i_cmd.h != '0);
                        if (!i_cmd.empty) begin
                            r_src_base <= i_cmd.src_base;
                            r_dst_base <= i_cmd.dst_base;
                        end
                    end
                    cbag_pkg::OP_STEP: begin
                        if (r_active) begin
                            if (row_end) begin
                                r_col      <= '0;
                                r_row      <= row_inc[DW-1:0];
                                r_src_base <= r_src_base + IW'(i_dims.src_w);
                                r_dst_base <= r_dst_base + IW'(i_dims.dst_w);
                                if (blit_end)
                                    r_active <= 1'b0;
                            end else begin
                                r_col <= col_inc[DW-1:0];
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_empty_res  = 1'b0;
        n_size_valid = 1'b0;
        n_clip_w     = '0;
        n_clip_h     = '0;
        n_pair_valid = 1'b0;
        n_src_idx    = '0;
        n_dst_idx    = '0;
        n_last       = 1'b0;
        case (i_cmd.op)
            cbag_pkg::OP_START: begin
                n_empty_res  = i_cmd.empty;
                n_size_valid = !i_cmd.empty;
                n_clip_w     = i_cmd.w;
                n_clip_h     = i_cmd.h;
            end
            cbag_pkg::OP_STEP: begin
                if (r_active) begin
                    n_pair_valid = 1'b1;
                    n_src_idx    = r_src_base + IW'(r_col);
                    n_dst_idx    = r_dst_base + IW'(r_col);
                    n_last       = blit_end;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_empty_res  <= n_empty_res;
            r_size_valid <= n_size_valid;
            r_clip_w     <= n_clip_w;
            r_clip_h     <= n_clip_h;
            r_pair_valid <= n_pair_valid;
            r_src_idx    <= n_src_idx;
            r_dst_idx    <= n_dst_idx;
            r_last       <= n_last;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.empty_res      = r_empty_res;
    assign o_res.size_valid     = r_size_valid;
    assign o_res.clipped_width  = r_clip_w;
    assign o_res.clipped_height = r_clip_h;
    assign o_res.pair_valid     = r_pair_valid;
    assign o_res.source_index   = r_src_idx;
    assign o_res.dest_index     = r_dst_idx;
    assign o_res.last           = r_last;

endmodule

`default_nettype wire

@@ design/clipped_rect_blit_address_gen.sv @@
// Top level of the clipped rectangle blit address generator.
// Depends on cbag_pkg, cbag_if, cbag_regs, cbag_front, cbag_queue and cbag_back.
//
// Takes one request per clock while the result output is not stalled, and gives one
// result per request, in order. A start request is clipped against the source and
// destination surfaces and answered with the empty flag and clipped size; each step
// request after it gets one source and destination element index pair, row by row,
// until the clipped rectangle is walked, with last on the final pair. From acceptance
// a request passes the clip register, the row base multiply stage, the queue and the
// output register. The sustained rate is one request per cycle when the output does
// not stall; the four entry queue absorbs stalls at the output, and the surface size
// registers may only be rewritten while the block is idle.
`default_nettype none

module clipped_rect_blit_address_gen (
    input  wire         i_clk,
    input  wire         i_rst_n,
    cbag_cfg_if.sink    i_cfg,
    cbag_req_if.sink    i_req,
    cbag_res_if.source  o_res
);

    cbag_pkg::t_dims  dims;
    cbag_pkg::t_cmd   front_cmd, queue_cmd;
    logic             front_valid, queue_full, queue_valid, queue_pop;

    cbag_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_dims  (dims)
    );

    cbag_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_dims      (dims),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (!queue_full)
    );

    cbag_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    cbag_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (dims),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

@@ design/cbag_checker.sv @@
// Port level checks for the blit address generator, bound to its top level.
// Depends on cbag_pkg and clipped_rect_blit_address_gen.
`default_nettype none

module cbag_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_res_valid,
    input  wire                             i_res_ready,
    input  wire                             i_empty_res,
    input  wire                             i_size_valid,
    input  wire [cbag_pkg::DIM_W-1:0]       i_clipped_width,
    input  wire [cbag_pkg::DIM_W-1:0]       i_clipped_height,
    input  wire                             i_pair_valid,
    input  wire [cbag_pkg::IDX_W-1:0]       i_source_index,
    input  wire                             i_last
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_source_index) && $stable(i_last))
        else $error("result payload changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> $countones({i_empty_res, i_size_valid, i_pair_valid}) <= 1)
        else $error("result mixes start and step answers");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_last |-> i_pair_valid)
        else $error("last without an index pair");

    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_size_valid |->
            i_clipped_width <= cbag_pkg::DIM_W'(cbag_pkg::MAX_DIM) &&
            i_clipped_height <= cbag_pkg::DIM_W'(cbag_pkg::MAX_DIM))
        else $error("clipped size beyond surface limit");

endmodule

bind clipped_rect_blit_address_gen cbag_checker u_cbag_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_empty_res      (o_res.empty_res),
    .i_size_valid     (o_res.size_valid),
    .i_clipped_width  (o_res.clipped_width),
    .i_clipped_height (o_res.clipped_height),
    .i_pair_valid     (o_res.pair_valid),
    .i_source_index   (o_res.source_index),
    .i_last           (o_res.last)
);

`default_nettype wire
